### design/nsnt_pkg.sv
// Shared types and constants for the node sequence number table.
package nsnt_pkg;

  // Fixed field widths of the request and response
  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 8;
  localparam int SEQ_W   = 16;
  localparam int ENTRY_W = 4;
  // Internal index width, wide enough for the deepest supported table
  localparam int IDX_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Request as held for the whole walk down the chain
  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
  } req_t;

  // Search state handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             hit;
    logic             added;
    logic [IDX_W-1:0] idx;
    logic [SEQ_W-1:0] seq;
  } carry_t;

  typedef struct packed {
    logic               success;
    logic [ENTRY_W-1:0] entry_index;
    logic [SEQ_W-1:0]   stored_sequence;
  } rsp_t;

endpackage

### design/nsnt_if.sv
// Request and response channel interfaces for the node sequence number table.
interface nsnt_req_if;
  import nsnt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] peer_addr;
  logic [SEQ_W-1:0]  new_sequence;
  modport source(output valid, command, peer_addr, new_sequence, input ready);
  modport sink(input valid, command, peer_addr, new_sequence, output ready);
endinterface

interface nsnt_rsp_if;
  import nsnt_pkg::*;
  logic               valid;
  logic               ready;
  logic               success;
  logic [ENTRY_W-1:0] entry_index;
  logic [SEQ_W-1:0]   stored_sequence;
  modport source(output valid, success, entry_index, stored_sequence, input ready);
  modport sink(input valid, success, entry_index, stored_sequence, output ready);
endinterface

### design/nsnt_cell.sv
// One table entry: holds an address and sequence number and passes the search on.
module nsnt_cell #(
  parameter int INDEX  = 0,
  parameter int FILL_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  nsnt_pkg::req_t    req,
  input  logic [FILL_W-1:0] fill_count,
  input  nsnt_pkg::carry_t  carry_in,
  output nsnt_pkg::carry_t  carry_out
);
  import nsnt_pkg::*;

  logic [ADDR_W-1:0] entry_addr;
  logic [SEQ_W-1:0]  entry_seq;
  logic              live;
  logic              tail;
  logic              match;
  logic              do_add;
  carry_t            carry_next;

  // Entry is live below the fill count; the first free slot sits at the fill count
  assign live   = FILL_W'(INDEX) < fill_count;
  assign tail   = FILL_W'(INDEX) == fill_count;
  assign match  = carry_in.active && live && !carry_in.hit && (entry_addr == req.addr);
  assign do_add = carry_in.active && (req.cmd == CMD_ADD) && tail && !carry_in.hit;

  // Fold this entry into the running search result
  always_comb begin
    carry_next = carry_in;
    if (match) begin
      carry_next.hit = 1'b1;
      carry_next.idx = IDX_W'(INDEX);
      carry_next.seq = entry_seq;
    end
    if (do_add) begin
      carry_next.added = 1'b1;
      carry_next.idx   = IDX_W'(INDEX);
    end
  end

  // Entry storage; no reset, only entries below the fill count are read
  always_ff @(posedge clk) begin
    priority if (do_add) begin
      entry_addr <= req.addr;
      entry_seq  <= req.seq;
    end else if (match && (req.cmd == CMD_UPDATE)) begin
      entry_seq <= req.seq;
    end
  end

  // Hand the search to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.active <= 1'b0;
    end else begin
      carry_out <= carry_next;
    end
  end

endmodule

### design/node_sequence_number_table.sv
// Top level of the node sequence number table: request launch, cell chain, response buffer.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------
//  req     | in  | valid / ready | command, peer_addr, new_sequence
//  rsp     | out | valid / ready | success, entry_index, stored_sequence
//
// A request walks the chain one cell per cycle; the next request is accepted
// only once the search leaves the last cell, so the chain length sets the gap.
// The response is then registered in the output register.
// Synchronous reset empties the table (fill count zero) and the response buffer.
// A stalled response waits in the output register; the next request is taken
// meanwhile and its response parks in a skid register. req.ready is low while
// a request is in the chain or the skid register is full.
module node_sequence_number_table #(
  parameter int TABLE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  nsnt_req_if.sink  req,
  nsnt_rsp_if.source rsp
);
  import nsnt_pkg::*;

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

  logic              busy;
  logic              accept;
  logic              done;
  req_t              req_q;
  carry_t            launch;
  carry_t            chain [TABLE_DEPTH+1];
  carry_t            fin;
  logic [TABLE_DEPTH-1:0] act_vec;
  logic [FILL_W-1:0] fill_count;
  rsp_t              result;
  logic              out_valid;
  logic              out_take;
  rsp_t              out_data;
  logic              skid_valid;
  rsp_t              skid_data;

  assign req.ready = !busy && !skid_valid;
  assign accept    = req.valid && req.ready;

  // Cell chain
  assign chain[0] = launch;
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    nsnt_cell #(
      .INDEX (i),
      .FILL_W(FILL_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .req       (req_q),
      .fill_count(fill_count),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1])
    );
    assign act_vec[i] = chain[i+1].active;
  end

  assign fin  = chain[TABLE_DEPTH];
  assign done = fin.active;

  // Shape the response from the finished search
  always_comb begin
    result = '0;
    unique case (req_q.cmd)
      CMD_LOOKUP: begin
        result.success     = fin.hit;
        result.entry_index = fin.hit ? fin.idx[ENTRY_W-1:0] : '0;
        result.stored_sequence = fin.hit ? fin.seq : '0;
      end
      CMD_ADD: begin
        result.success     = fin.added;
        result.entry_index = fin.added ? fin.idx[ENTRY_W-1:0] : '0;
      end
      CMD_UPDATE: begin
        result.success     = fin.hit;
        result.entry_index = fin.hit ? fin.idx[ENTRY_W-1:0] : '0;
      end
      CMD_NONE: begin
        result = '0;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // Request capture and launch into the chain
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q.cmd  <= cmd_t'(req.command);
      req_q.addr <= req.peer_addr;
      req_q.seq  <= req.new_sequence;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch.active <= 1'b0;
    end else begin
      launch <= carry_t'{active: accept, default: '0};
    end
  end

  // Busy flag and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      fill_count <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (done) begin
        busy <= 1'b0;
        if (fin.added && (req_q.cmd == CMD_ADD)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  // Output register with skid stage
  assign out_take = out_valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (done && (!out_valid || rsp.ready)) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else if (out_take) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
      // Held response: park the new one behind it
      if (done && out_valid && !rsp.ready) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.success         = out_data.success;
  assign rsp.entry_index     = out_data.entry_index;
  assign rsp.stored_sequence = out_data.stored_sequence;

  // At most one request walks the chain
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({act_vec, launch.active}))
    else $error("more than one request in the cell chain");

  // The fill count never passes the table depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // The table grows by at most one entry per cycle
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fill_count == $past(fill_count)) ||
                    (fill_count == $past(fill_count) + 1'b1))
    else $error("fill count jumped");

  // The skid register only fills behind a held response
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full with output register empty");

  // An accepted request marks the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request accepted without busy flag");

endmodule

### bench/tb_top.sv
// Self-checking testbench for the node sequence number table.
`timescale 1ns / 1ps

module tb_top;
  import nsnt_pkg::*;

  localparam int TABLE_DEPTH    = 16;
  localparam int RANDOM_ITEMS   = 700;
  localparam int HOLD_OFF       = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  // Scoreboard: keeps its own copy of the table and queues the expected response per request
  class seq_table_scoreboard #(int DEPTH = 16);
    logic [ADDR_W-1:0] node_of [DEPTH];
    logic [SEQ_W-1:0]  last_seq [DEPTH];
    int   entries_used;
    rsp_t expected_rsp [$];
    int   errors;
    int   checked;
    int   full_refusals;
    int   issued [4];
    int   succeeded [4];

    function new();
      entries_used  = 0;
      errors        = 0;
      checked       = 0;
      full_refusals = 0;
      foreach (issued[k]) begin
        issued[k]    = 0;
        succeeded[k] = 0;
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Apply one accepted request to the table copy and queue its response
    function void note_request(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [SEQ_W-1:0] seq);
      rsp_t r;
      bit   hit;
      int   where;
      r     = '0;
      hit   = 1'b0;
      where = 0;
      // lowest valid entry with a matching address wins
      for (int i = 0; i < entries_used; i++) begin
        if (!hit && node_of[i] == addr) begin
          hit   = 1'b1;
          where = i;
        end
      end
      case (cmd)
        CMD_LOOKUP: begin
          if (hit) begin
            r.success         = 1'b1;
            r.entry_index     = ENTRY_W'(where);
            r.stored_sequence = last_seq[where];
          end
        end
        CMD_ADD: begin
          if (!hit && entries_used < DEPTH) begin
            node_of[entries_used]  = addr;
            last_seq[entries_used] = seq;
            r.success              = 1'b1;
            r.entry_index          = ENTRY_W'(entries_used);
            entries_used++;
          end else if (!hit) begin
            full_refusals++;
          end
        end
        CMD_UPDATE: begin
          if (hit) begin
            last_seq[where] = seq;
            r.success       = 1'b1;
            r.entry_index   = ENTRY_W'(where);
          end
        end
        default: ;
      endcase
      issued[cmd]++;
      if (r.success) succeeded[cmd]++;
      expected_rsp.push_back(r);
    endfunction

    // Compare one accepted response against the oldest expectation
    function void check_response(logic ok, logic [ENTRY_W-1:0] idx, logic [SEQ_W-1:0] seq);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      checked++;
      if (ok !== want.success) begin
        $error("success: expected %0d, got %0d", want.success, ok);
        errors++;
      end
      if (idx !== want.entry_index) begin
        $error("entry_index: expected %0d, got %0d", want.entry_index, idx);
        errors++;
      end
      if (seq !== want.stored_sequence) begin
        $error("stored_sequence: expected 0x%0h, got 0x%0h", want.stored_sequence, seq);
        errors++;
      end
    endfunction
  endclass

  typedef seq_table_scoreboard #(TABLE_DEPTH) scoreboard_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nsnt_req_if req_ch ();
  nsnt_rsp_if rsp_ch ();

  node_sequence_number_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  scoreboard_t sb = new();

  logic [ADDR_W-1:0] addr_pool [32];
  int tx_flow_left  = 0;
  int rx_flow_left  = 0;
  int rx_stall_left = 0;
  int hold_off_req  = 0;
  int idle_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly short, now and then long
  function int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request, with a random gap first, and wait for it to be taken
  task automatic send_request(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [SEQ_W-1:0] seq);
    int gap;
    if (tx_flow_left > 0) begin
      tx_flow_left--;
      gap = 0;
    end else begin
      gap = ($urandom_range(0, 99) < 55) ? 0 : idle_len();
    end
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= cmd;
    req_ch.peer_addr    <= addr;
    req_ch.new_sequence <= seq;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(cmd, addr, seq);
  endtask

  // Response side ready: random stalls, free-flowing runs, and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      rx_stall_left--;
    end else if (hold_off_req != 0) begin
      hold_off_req  = 0;
      rx_stall_left = HOLD_OFF - 1;
      rsp_ch.ready <= 1'b0;
    end else if (rx_flow_left != 0) begin
      rsp_ch.ready <= 1'b1;
      rx_flow_left--;
    end else begin
      case ($urandom_range(0, 3))
        0, 1: rsp_ch.ready <= 1'b1;
        2: begin
          rsp_ch.ready <= 1'b0;
          rx_stall_left = idle_len() - 1;
        end
        default: begin
          rsp_ch.ready <= 1'b1;
          rx_flow_left = $urandom_range(20, 80);
        end
      endcase
    end
  end

  // Response checking
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_response(rsp_ch.success, rsp_ch.entry_index, rsp_ch.stored_sequence);
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                 idle_cycles, sb.pending());
        $display("node_sequence_number_table regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int   r;
    cmd_t cmd;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;

    req_ch.valid        = 1'b0;
    req_ch.command      = '0;
    req_ch.peer_addr    = '0;
    req_ch.new_sequence = '0;
    for (int i = 0; i < 32; i++)
      addr_pool[i] = {3'($urandom_range(0, 7)), 5'(i)};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, edge addresses and sequences, duplicates, no-op
    send_request(CMD_LOOKUP, 8'h00, 16'h0000);
    send_request(CMD_UPDATE, 8'h12, 16'h1234);
    send_request(CMD_NONE,   8'h00, 16'h0000);
    send_request(CMD_ADD,    8'h00, 16'h0000);
    send_request(CMD_ADD,    8'hFF, 16'hFFFF);
    send_request(CMD_ADD,    8'h00, 16'h5555);
    send_request(CMD_ADD,    8'hFF, 16'h0000);
    send_request(CMD_LOOKUP, 8'hFF, 16'h0000);
    send_request(CMD_LOOKUP, 8'h00, 16'hFFFF);
    send_request(CMD_UPDATE, 8'hFF, 16'h0000);
    send_request(CMD_UPDATE, 8'h00, 16'hFFFF);
    send_request(CMD_LOOKUP, 8'hFF, 16'hAAAA);
    send_request(CMD_LOOKUP, 8'h00, 16'h0000);
    send_request(CMD_LOOKUP, 8'h80, 16'h0000);
    send_request(CMD_UPDATE, 8'h7F, 16'hFFFF);
    send_request(CMD_NONE,   8'hFF, 16'hFFFF);

    // Random: mostly a small address pool so lookups and updates hit
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 50) tx_flow_left = 40;
      if (n == 300) begin
        hold_off_req = 1;
        tx_flow_left = 60;
      end
      r = $urandom_range(0, 99);
      if (r < 44)      cmd = CMD_LOOKUP;
      else if (r < 56) cmd = CMD_ADD;
      else if (r < 96) cmd = CMD_UPDATE;
      else             cmd = CMD_NONE;
      if ($urandom_range(0, 99) < 80) addr = addr_pool[$urandom_range(0, 31)];
      else                            addr = ADDR_W'($urandom_range(0, 255));
      r = $urandom_range(0, 9);
      if (r == 0)      seq = 16'h0000;
      else if (r == 1) seq = 16'hFFFF;
      else             seq = SEQ_W'($urandom_range(0, 65535));
      send_request(cmd, addr, seq);
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Drain, then wait a little over one pipeline length for any stray response
    while (sb.pending() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("checked %0d responses: lookups %0d (%0d hit), adds %0d (%0d stored, %0d refused full)",
             sb.checked, sb.issued[CMD_LOOKUP], sb.succeeded[CMD_LOOKUP],
             sb.issued[CMD_ADD], sb.succeeded[CMD_ADD], sb.full_refusals);
    $display("updates %0d (%0d applied), no-ops %0d, final fill %0d of %0d, %0d mismatches",
             sb.issued[CMD_UPDATE], sb.succeeded[CMD_UPDATE], sb.issued[CMD_NONE],
             sb.entries_used, TABLE_DEPTH, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("node_sequence_number_table regression: pass");
    else
      $display("node_sequence_number_table regression: fail");
    $finish;
  end
endmodule
